@@ hdl/tca_pkg.sv @@
// Shared types and codes for the tiered capacity admission block.
// No dependencies.
package tca_pkg;

    localparam int SLOT_W = 16;
    localparam int FIELD_W = 16;
    localparam int AMOUNT_WIDTH = 16;
    localparam int CFG_INDEX_W = 3;

    // Status codes
    localparam logic [1:0] STATUS_GRANTED     = 2'd0;
    localparam logic [1:0] STATUS_NO_CAPACITY = 2'd1;
    localparam logic [1:0] STATUS_SLOT_LIMIT  = 2'd2;

    // Operation codes
    localparam logic FUNC_RESERVE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_POOLED_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIER0_CAP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOLED_CAP   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_NORMAL   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SWITCHED = 3'd7;

    typedef struct packed {
        logic               func;
        logic [1:0]         tier_index;
        logic [FIELD_W-1:0] needed_amount;
        logic [FIELD_W-1:0] pooled_amount;
        logic               counts_slot;
        logic               switched_kind;
        logic               last_element;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] normal_slots_left;
        logic [SLOT_W-1:0] switched_slots_left;
    } rsp_item_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic exec_done;
        logic last;
        logic out_blocked;
    } dp_status_t;

endpackage

@@ hdl/tiered_capacity_admission_top.sv @@
// Top level of the tiered capacity admission block.
// Depends on tca_pkg, tca_ctrl and tca_datapath.
//
//  channel | handshake             | beat
//  --------+-----------------------+--------------------------------------
//  req     | req_valid / req_stall | one tier element of a request
//  rsp     | rsp_valid / rsp_stall | status and slot counts, on last element
//  cfg     | cfg_valid / cfg_ready | register index and write data
//
// Sequence: an element is captured, then the walk state works through the tiers
// visited by the upward spill walk, and on the last element a settle state
// commits the request once the result register has room.
// Reset: rst_n clears all capacities, slot counters and mode to zero.
// Stalls: the result sits in an output register; the next request is taken
// while it waits, and only the settling of a later last element holds off.
// cfg_ready is always high; writes are expected only while the block is idle.
module tiered_capacity_admission_top
    import tca_pkg::*;
#(
    parameter int NUM_TIERS    = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_item_t              req_item,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_item_t              rsp_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    // State machine: capture, walk, settle
    tca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Capacity and slot state, spill walk and result register
    tca_datapath #(
        .NUM_TIERS    (NUM_TIERS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

@@ hdl/tca_ctrl.sv @@
// Sequencing state machine for the tiered capacity admission block.
// Depends on tca_pkg.
module tca_ctrl
    import tca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.exec_done)
                    state_next = stat.last ? ST_END : ST_IDLE;
            end
            ST_END:
            begin
                // wait for room in the result register
                if (!stat.out_blocked)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hdl/tca_datapath.sv @@
// Capacity, shadow, pooled and slot state, tier walk and result register.
// Depends on tca_pkg.
module tca_datapath
    import tca_pkg::*;
#(
    parameter int NUM_TIERS    = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data,
    input  req_item_t              req_item,
    input  dp_cmd_t                cmd,
    output dp_status_t             stat,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_item_t              rsp_item
);

    localparam int TIER_IDX_W = $clog2(NUM_TIERS);
    localparam logic [TIER_IDX_W-1:0] LAST_TIER = TIER_IDX_W'(NUM_TIERS - 1);
    localparam logic [AMOUNT_WIDTH-1:0] AMT_MAX = {AMOUNT_WIDTH{1'b1}};

    logic [AMOUNT_WIDTH-1:0] free_reg   [NUM_TIERS];
    logic [AMOUNT_WIDTH-1:0] free_next  [NUM_TIERS];
    logic [AMOUNT_WIDTH-1:0] shadow_reg [NUM_TIERS];
    logic [AMOUNT_WIDTH-1:0] shadow_next[NUM_TIERS];
    logic [AMOUNT_WIDTH-1:0] pooled_reg, pooled_next;
    logic [SLOT_W-1:0]       normal_reg, normal_next;
    logic [SLOT_W-1:0]       switched_reg, switched_next;
    logic                    mode_reg, mode_next;
    logic                    failed_reg, failed_next;

    req_item_t               item_reg, item_next;
    logic [AMOUNT_WIDTH-1:0] need_reg, need_next;
    logic [TIER_IDX_W-1:0]   j_reg, j_next;

    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_item_reg, rsp_item_next;

    logic                    tier_active;
    logic [TIER_IDX_W-1:0]   t_idx;
    logic [AMOUNT_WIDTH-1:0] sh;
    logic [AMOUNT_WIDTH-1:0] pooled_need;
    logic [AMOUNT_WIDTH:0]   sum_free;
    logic [AMOUNT_WIDTH:0]   sum_shadow;
    logic [AMOUNT_WIDTH:0]   sum_pooled;
    logic                    cap_fail;
    logic                    slot_zero;
    logic                    exec_done;
    logic [1:0]              status;

    assign tier_active = !mode_reg && (int'(item_reg.tier_index) < NUM_TIERS);
    assign t_idx       = item_reg.tier_index[TIER_IDX_W-1:0];
    assign sh          = shadow_reg[j_reg];
    assign pooled_need = AMOUNT_WIDTH'(item_reg.pooled_amount);
    assign sum_free    = {1'b0, free_reg[t_idx]} + {1'b0, need_reg};
    assign sum_shadow  = {1'b0, shadow_reg[t_idx]} + {1'b0, need_reg};
    assign sum_pooled  = {1'b0, pooled_reg} + {1'b0, pooled_need};
    assign cap_fail    = failed_reg || (mode_reg && (pooled_reg < pooled_need));
    assign slot_zero   = item_reg.counts_slot &&
                         ((item_reg.switched_kind ? switched_reg : normal_reg) == '0);

    always_comb
    begin
        free_next      = free_reg;
        shadow_next    = shadow_reg;
        pooled_next    = pooled_reg;
        normal_next    = normal_reg;
        switched_next  = switched_reg;
        mode_next      = mode_reg;
        failed_next    = failed_reg;
        item_next      = item_reg;
        need_next      = need_reg;
        j_next         = j_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        exec_done      = 1'b1;
        status         = STATUS_GRANTED;

        if (cmd.capture)
        begin
            item_next = req_item;
            need_next = AMOUNT_WIDTH'(req_item.needed_amount);
            j_next    = req_item.tier_index[TIER_IDX_W-1:0];
        end

        if (cmd.exec && tier_active)
        begin
            if (item_reg.func == FUNC_RELEASE)
            begin
                free_next[t_idx]   = sum_free[AMOUNT_WIDTH] ? AMT_MAX
                                                            : sum_free[AMOUNT_WIDTH-1:0];
                shadow_next[t_idx] = sum_shadow[AMOUNT_WIDTH] ? AMT_MAX
                                                              : sum_shadow[AMOUNT_WIDTH-1:0];
            end
            else if (!failed_reg)
            begin
                // one tier of the upward walk per cycle
                if (sh >= need_reg)
                    shadow_next[j_reg] = sh - need_reg;
                else if (j_reg == '0)
                    failed_next = 1'b1;
                else
                begin
                    need_next          = need_reg - sh;
                    shadow_next[j_reg] = '0;
                    if (j_reg == LAST_TIER)
                        failed_next = 1'b1;
                    else
                    begin
                        j_next    = j_reg + 1'b1;
                        exec_done = 1'b0;
                    end
                end
            end
        end

        if (cmd.finish)
        begin
            if (item_reg.func == FUNC_RELEASE)
            begin
                if (mode_reg)
                    pooled_next = sum_pooled[AMOUNT_WIDTH] ? AMT_MAX
                                                           : sum_pooled[AMOUNT_WIDTH-1:0];
                if (item_reg.counts_slot)
                begin
                    if (item_reg.switched_kind)
                    begin
                        if (switched_reg != '1)
                            switched_next = switched_reg + 1'b1;
                    end
                    else if (normal_reg != '1)
                        normal_next = normal_reg + 1'b1;
                end
            end
            else
            begin
                priority if (cap_fail)
                    status = STATUS_NO_CAPACITY;
                else if (slot_zero)
                    status = STATUS_SLOT_LIMIT;
                else
                    status = STATUS_GRANTED;
                if (status == STATUS_GRANTED)
                begin
                    if (mode_reg)
                        pooled_next = pooled_reg - pooled_need;
                    else
                        free_next = shadow_reg;
                    if (item_reg.counts_slot)
                    begin
                        if (item_reg.switched_kind)
                            switched_next = switched_reg - 1'b1;
                        else
                            normal_next = normal_reg - 1'b1;
                    end
                end
            end
            shadow_next = free_next;
            failed_next = 1'b0;
            rsp_valid_next                    = 1'b1;
            rsp_item_next.status              = status;
            rsp_item_next.normal_slots_left   = normal_next;
            rsp_item_next.switched_slots_left = switched_next;
        end

        if (cfg_we)
        begin
            if (cfg_index == CFG_POOLED_MODE)
                mode_next = cfg_data[0];
            if (cfg_index == CFG_POOLED_CAP)
                pooled_next = AMOUNT_WIDTH'(cfg_data);
            if (cfg_index == CFG_MAX_NORMAL)
                normal_next = cfg_data;
            if (cfg_index == CFG_MAX_SWITCHED)
                switched_next = cfg_data;
            for (int i = 0; i < NUM_TIERS; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(int'(CFG_TIER0_CAP) + i))
                begin
                    free_next[i]   = AMOUNT_WIDTH'(cfg_data);
                    shadow_next[i] = AMOUNT_WIDTH'(cfg_data);
                end
            end
        end
    end

    assign stat.exec_done   = exec_done;
    assign stat.last        = item_reg.last_element;
    assign stat.out_blocked = rsp_valid_reg && rsp_stall;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp_item         = rsp_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIERS; i++)
            begin
                free_reg[i]   <= '0;
                shadow_reg[i] <= '0;
            end
            pooled_reg    <= '0;
            normal_reg    <= '0;
            switched_reg  <= '0;
            mode_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            free_reg      <= free_next;
            shadow_reg    <= shadow_next;
            pooled_reg    <= pooled_next;
            normal_reg    <= normal_next;
            switched_reg  <= switched_next;
            mode_reg      <= mode_next;
            failed_reg    <= failed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        need_reg     <= need_next;
        j_reg        <= j_next;
        rsp_item_reg <= rsp_item_next;
    end

endmodule

@@ tb/tca_admission_checker.sv @@
// Scoreboard for the tiered capacity admission block: tracks capacities, slot
// counters and mode from observed beats, and checks every status beat.
// Depends on tca_pkg.
module tca_admission_checker
    import tca_pkg::*;
#(
    parameter int NUM_TIERS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  req_item_t              req_item,
    input  logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  rsp_item_t              rsp_item,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data,
    output int                     fail_count,
    output int                     pending_count,
    output int                     beats_seen,
    output int                     ok_seen,
    output int                     short_seen,
    output int                     slot_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [FIELD_W-1:0] tier_free   [NUM_TIERS];
    logic [FIELD_W-1:0] tier_shadow [NUM_TIERS];
    logic [FIELD_W-1:0] pooled_free;
    logic [SLOT_W-1:0]  normal_slots;
    logic [SLOT_W-1:0]  switched_slots;
    logic               pooled_mode;
    logic               request_failed;

    rsp_item_t status_queue [$];
    int        n_fail;
    int        n_beats;
    int        n_ok;
    int        n_short;
    int        n_slot;

    function automatic logic [FIELD_W-1:0] add_sat(input logic [FIELD_W-1:0] a,
                                                   input logic [FIELD_W-1:0] b);
        logic [FIELD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[FIELD_W] ? '1 : sum[FIELD_W-1:0];
    endfunction

    // Own tier first; tier 0 cannot borrow, higher tiers walk upward.
    task automatic take_from_tier(input int t, input logic [FIELD_W-1:0] need);
        logic [FIELD_W-1:0] rest;
        bit                 covered;
        rest    = need;
        covered = 1'b0;
        if (tier_shadow[t] >= rest)
        begin
            tier_shadow[t] = tier_shadow[t] - rest;
        end
        else if (t == 0)
        begin
            request_failed = 1'b1;
        end
        else
        begin
            for (int j = t; j < NUM_TIERS; j++)
            begin
                if (!covered)
                begin
                    if (tier_shadow[j] >= rest)
                    begin
                        tier_shadow[j] = tier_shadow[j] - rest;
                        rest           = '0;
                        covered        = 1'b1;
                    end
                    else
                    begin
                        rest           = rest - tier_shadow[j];
                        tier_shadow[j] = '0;
                    end
                end
            end
            if (rest != '0)
                request_failed = 1'b1;
        end
    endtask

    task automatic apply_beat(input req_item_t it);
        rsp_item_t         res;
        logic [1:0]        st;
        logic [SLOT_W-1:0] left;
        if (!pooled_mode && it.tier_index < NUM_TIERS)
        begin
            if (it.func == FUNC_RELEASE)
            begin
                tier_free[it.tier_index]   = add_sat(tier_free[it.tier_index], it.needed_amount);
                tier_shadow[it.tier_index] = add_sat(tier_shadow[it.tier_index],
                                                     it.needed_amount);
            end
            else if (!request_failed)
            begin
                take_from_tier(int'(it.tier_index), it.needed_amount);
            end
        end
        if (it.last_element)
        begin
            st = STATUS_GRANTED;
            if (it.func == FUNC_RELEASE)
            begin
                if (pooled_mode)
                    pooled_free = add_sat(pooled_free, it.pooled_amount);
                if (it.counts_slot && it.switched_kind)
                    switched_slots = add_sat(switched_slots, FIELD_W'(1));
                else if (it.counts_slot)
                    normal_slots = add_sat(normal_slots, FIELD_W'(1));
            end
            else
            begin
                if (pooled_mode && pooled_free < it.pooled_amount)
                    request_failed = 1'b1;
                left = it.switched_kind ? switched_slots : normal_slots;
                if (request_failed)
                    st = STATUS_NO_CAPACITY;
                else if (it.counts_slot && left == '0)
                    st = STATUS_SLOT_LIMIT;
                if (st == STATUS_GRANTED)
                begin
                    if (pooled_mode)
                        pooled_free = pooled_free - it.pooled_amount;
                    else
                        for (int t = 0; t < NUM_TIERS; t++)
                            tier_free[t] = tier_shadow[t];
                    if (it.counts_slot && it.switched_kind)
                        switched_slots = switched_slots - 1'b1;
                    else if (it.counts_slot)
                        normal_slots = normal_slots - 1'b1;
                end
            end
            for (int t = 0; t < NUM_TIERS; t++)
                tier_shadow[t] = tier_free[t];
            request_failed          = 1'b0;
            res.status              = st;
            res.normal_slots_left   = normal_slots;
            res.switched_slots_left = switched_slots;
            status_queue.push_back(res);
        end
    endtask

    task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [FIELD_W-1:0] val);
        if (idx == CFG_POOLED_MODE)
            pooled_mode = val[0];
        else if (idx == CFG_POOLED_CAP)
            pooled_free = val;
        else if (idx == CFG_MAX_NORMAL)
            normal_slots = val;
        else if (idx == CFG_MAX_SWITCHED)
            switched_slots = val;
        else if (idx >= CFG_TIER0_CAP && int'(idx - CFG_TIER0_CAP) < NUM_TIERS)
        begin
            tier_free[idx - CFG_TIER0_CAP]   = val;
            tier_shadow[idx - CFG_TIER0_CAP] = val;
        end
    endtask

    task automatic check_result(input rsp_item_t got);
        rsp_item_t want;
        if (status_queue.size() == 0)
        begin
            $error("unexpected status beat: status %0d normal %0d switched %0d",
                   got.status, got.normal_slots_left, got.switched_slots_left);
            n_fail++;
        end
        else
        begin
            want = status_queue.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                n_fail++;
            end
            if (got.normal_slots_left !== want.normal_slots_left)
            begin
                $error("normal_slots_left: expected %0d, got %0d",
                       want.normal_slots_left, got.normal_slots_left);
                n_fail++;
            end
            if (got.switched_slots_left !== want.switched_slots_left)
            begin
                $error("switched_slots_left: expected %0d, got %0d",
                       want.switched_slots_left, got.switched_slots_left);
                n_fail++;
            end
            if (want.status == STATUS_GRANTED)
                n_ok++;
            else if (want.status == STATUS_NO_CAPACITY)
                n_short++;
            else
                n_slot++;
        end
    endtask

    // Outputs are copied with nonblocking writes so the stimulus side always
    // reads the totals as of the previous edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TIERS; t++)
            begin
                tier_free[t]   = '0;
                tier_shadow[t] = '0;
            end
            pooled_free    = '0;
            normal_slots   = '0;
            switched_slots = '0;
            pooled_mode    = 1'b0;
            request_failed = 1'b0;
            status_queue.delete();
            n_fail  = 0;
            n_beats = 0;
            n_ok    = 0;
            n_short = 0;
            n_slot  = 0;
            fail_count    <= 0;
            pending_count <= 0;
            beats_seen    <= 0;
            ok_seen       <= 0;
            short_seen    <= 0;
            slot_seen     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_setting(cfg_index, cfg_data);
            if (req_valid && !req_stall)
            begin
                n_beats++;
                apply_beat(req_item);
            end
            if (rsp_valid && !rsp_stall)
                check_result(rsp_item);
            fail_count    <= n_fail;
            pending_count <= status_queue.size();
            beats_seen    <= n_beats;
            ok_seen       <= n_ok;
            short_seen    <= n_short;
            slot_seen     <= n_slot;
        end
    end

endmodule

@@ tb/tiered_capacity_admission_top_test.sv @@
// Testbench top for the tiered capacity admission block: clock, reset,
// register programming, request stimulus, response backpressure and verdict.
// Depends on tca_pkg, tiered_capacity_admission_top and tca_admission_checker.
module tiered_capacity_admission_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tca_pkg::*;

    localparam int NUM_TIERS    = 4;
    localparam int RANDOM_BEATS = 850;
    localparam int PHASE_BEATS  = 100;
    // Wait well past the settling of a last element before touching registers
    // or ending the run.
    localparam int DRAIN_CYCLES = 2 * (NUM_TIERS + 2) + 4;
    // The limit sits well above the slowest legal run (every beat walking all
    // tiers, long sender gaps, every status beat held by a long stall).
    localparam int CYCLE_LIMIT  = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_item_t              req_item;
    logic                   rsp_valid;
    logic                   rsp_stall;
    rsp_item_t              rsp_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]     cfg_data;

    int fail_count;
    int pending_count;
    int beats_seen;
    int ok_seen;
    int short_seen;
    int slot_seen;

    // Sender burst state and run bookkeeping.
    int                 burst_left;
    int                 beats_sent;
    int                 phases_run;
    int                 cycle_count;
    logic [FIELD_W-1:0] tier_caps [NUM_TIERS];

    tiered_capacity_admission_top #(
        .NUM_TIERS    (NUM_TIERS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tca_admission_checker #(
        .NUM_TIERS (NUM_TIERS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_item      (req_item),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_item      (rsp_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .beats_seen    (beats_seen),
        .ok_seen       (ok_seen),
        .short_seen    (short_seen),
        .slot_seen     (slot_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung block or a lost status beat ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Response backpressure. The pattern switches at random between no stall,
    // coin-flip stall, long on/off runs and rare stalls, so the output register
    // gets held at every point of the settle phase.
    initial
    begin
        int stall_mode;
        int mode_left;
        int run_left;
        bit run_on;
        stall_mode = 0;
        mode_left  = 0;
        run_left   = 0;
        run_on     = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(30, 200);
            end
            mode_left--;
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= 1'($urandom_range(0, 1));
                2:
                begin
                    if (run_left == 0)
                    begin
                        run_on   = !run_on;
                        run_left = $urandom_range(1, 20);
                    end
                    run_left--;
                    rsp_stall <= run_on;
                end
                default: rsp_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic req_item_t make_beat(input logic func,
                                            input logic [1:0] tier,
                                            input logic [FIELD_W-1:0] need,
                                            input logic [FIELD_W-1:0] pooled,
                                            input logic counts,
                                            input logic switched,
                                            input logic last);
        req_item_t it;
        it.func          = func;
        it.tier_index    = tier;
        it.needed_amount = need;
        it.pooled_amount = pooled;
        it.counts_slot   = counts;
        it.switched_kind = switched;
        it.last_element  = last;
        return it;
    endfunction

    // Mostly amounts that fit the small capacities of the random phases,
    // with zero, the full-scale value and full-range values mixed in.
    function automatic logic [FIELD_W-1:0] pick_amount();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r <= 3)
            return FIELD_W'($urandom);
        return FIELD_W'($urandom_range(0, 400));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return FIELD_W'($urandom);
        return FIELD_W'($urandom_range(0, 3000));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slots();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return SLOT_W'($urandom_range(0, 6));
    endfunction

    // One register write; valid stays up so writes go back to back.
    task automatic put_setting(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [FIELD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes every register; tier capacities come from tier_caps.
    task automatic load_settings(input logic pooled,
                                 input logic [FIELD_W-1:0] pooled_cap,
                                 input logic [SLOT_W-1:0] normal,
                                 input logic [SLOT_W-1:0] switched);
        put_setting(CFG_POOLED_MODE, FIELD_W'(pooled));
        for (int t = 0; t < NUM_TIERS; t++)
            put_setting(CFG_TIER0_CAP + CFG_INDEX_W'(t), tier_caps[t]);
        put_setting(CFG_POOLED_CAP, pooled_cap);
        put_setting(CFG_MAX_NORMAL, normal);
        put_setting(CFG_MAX_SWITCHED, switched);
        cfg_valid <= 1'b0;
        phases_run++;
    endtask

    // Sender: bursts of back-to-back beats separated by random idle gaps.
    task automatic send_beat(input req_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do
            @(posedge clk);
        while (req_stall);
        burst_left--;
        beats_sent++;
    endtask

    // Stop sending, let every status beat come back, then let the block
    // finish any settling before registers are touched again.
    task automatic wait_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Well-formed request: one function, tiers ascending from a nonzero mask,
    // the last flag on the highest tier present.
    task automatic send_request();
        logic       func;
        logic [3:0] mask;
        int         top_tier;
        func     = ($urandom_range(0, 9) < 6) ? FUNC_RESERVE : FUNC_RELEASE;
        mask     = 4'($urandom_range(1, (1 << NUM_TIERS) - 1));
        top_tier = 0;
        for (int t = 0; t < NUM_TIERS; t++)
            if (mask[t])
                top_tier = t;
        for (int t = 0; t < NUM_TIERS; t++)
            if (mask[t])
                send_beat(make_beat(func, 2'(t), pick_amount(), pick_amount(),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    t == top_tier));
    endtask

    // Broken request: tiers in any order, function chosen at random per beat.
    task automatic send_noise_request();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
            send_beat(make_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                FIELD_W'($urandom), FIELD_W'($urandom),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                k == n - 1));
    endtask

    initial
    begin
        int random_start;
        int phase_start;
        int phase;
        logic pooled;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req_item   <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        burst_left = 0;
        beats_sent = 0;
        phases_run = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, per-tier mode. Amounts in sixteenths of a unit.
        tier_caps = '{16'd100, 16'd50, 16'd30, 16'd20};
        load_settings(1'b0, 16'd0, 16'd1, 16'd0);
        // plain reserve that takes the only normal slot
        send_beat(make_beat(FUNC_RESERVE, 2'd0, 16'd40, 16'd0, 1'b1, 1'b0, 1'b1));
        // upward spill succeeds on capacity but the normal slots are gone
        send_beat(make_beat(FUNC_RESERVE, 2'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(FUNC_RESERVE, 2'd1, 16'd60, 16'd0, 1'b1, 1'b0, 1'b1));
        // tier 0 shortfall; later beats ignored; capacity beats slot limit
        send_beat(make_beat(FUNC_RESERVE, 2'd0, 16'd61, 16'd0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(FUNC_RESERVE, 2'd1, 16'd5, 16'd0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(FUNC_RESERVE, 2'd2, 16'd5, 16'd0, 1'b1, 1'b0, 1'b1));
        // spill drains tiers 1..3 exactly
        send_beat(make_beat(FUNC_RESERVE, 2'd1, 16'd100, 16'd0, 1'b0, 1'b0, 1'b1));
        // spill from an empty tier fails
        send_beat(make_beat(FUNC_RESERVE, 2'd2, 16'd1, 16'd0, 1'b0, 1'b1, 1'b1));
        // release saturates tier 0 and returns a switched slot
        send_beat(make_beat(FUNC_RELEASE, 2'd0, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(FUNC_RELEASE, 2'd3, 16'd7, 16'd0, 1'b1, 1'b1, 1'b1));
        // mixed request ending in release drops the pending reserve
        send_beat(make_beat(FUNC_RESERVE, 2'd0, 16'd10, 16'd0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(FUNC_RELEASE, 2'd1, 16'd5, 16'd0, 1'b0, 1'b0, 1'b1));
        // full-scale reserve on the switched slot
        send_beat(make_beat(FUNC_RESERVE, 2'd0, 16'hFFFF, 16'd0, 1'b1, 1'b1, 1'b1));
        wait_idle();

        // Directed, pooled mode: tier amounts are not used on reserve.
        tier_caps = '{16'd0, 16'd0, 16'd0, 16'd0};
        load_settings(1'b1, 16'd200, 16'd0, 16'd2);
        send_beat(make_beat(FUNC_RESERVE, 2'd0, 16'd9999, 16'd150, 1'b1, 1'b1, 1'b1));
        // pooled shortfall leaves the pool untouched
        send_beat(make_beat(FUNC_RESERVE, 2'd0, 16'd0, 16'd51, 1'b0, 1'b0, 1'b1));
        send_beat(make_beat(FUNC_RESERVE, 2'd1, 16'd0, 16'd50, 1'b1, 1'b0, 1'b1));
        // pooled release saturates; tier release does nothing here
        send_beat(make_beat(FUNC_RELEASE, 2'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(FUNC_RELEASE, 2'd2, 16'd100, 16'd0, 1'b0, 1'b0, 1'b1));
        send_beat(make_beat(FUNC_RESERVE, 2'd3, 16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        wait_idle();

        // Directed, everything at full scale: slot counters saturate on release.
        tier_caps = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(make_beat(FUNC_RELEASE, 2'd0, 16'd1, 16'd0, 1'b1, 1'b0, 1'b1));
        send_beat(make_beat(FUNC_RELEASE, 2'd3, 16'd1, 16'd0, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(FUNC_RESERVE, 2'd3, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b1));
        wait_idle();

        // Random phases: the first two pin every register to its extreme,
        // then mixes of small and full-range settings, roughly one in three
        // in pooled mode. Most requests are well formed.
        random_start = beats_sent;
        phase        = 0;
        while (beats_sent - random_start < RANDOM_BEATS)
        begin
            for (int t = 0; t < NUM_TIERS; t++)
                tier_caps[t] = (phase == 0) ? '0 : (phase == 1) ? '1 : pick_capacity();
            if (phase == 0)
                load_settings(1'b0, '0, '0, '0);
            else if (phase == 1)
                load_settings(1'b1, '1, '1, '1);
            else
            begin
                pooled = ($urandom_range(0, 2) == 0);
                load_settings(pooled, pick_capacity(), pick_slots(), pick_slots());
            end
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS &&
                   beats_sent - random_start < RANDOM_BEATS)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise_request();
                else
                    send_request();
            end
            wait_idle();
            phase++;
        end

        $display("Sent %0d request beats over %0d register settings (per-tier and pooled).",
                 beats_seen, phases_run);
        $display("Status beats checked: %0d ok, %0d short of capacity, %0d at slot limit.",
                 ok_seen, short_seen, slot_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
